// ===== hw/rtl/cmip_pkg.sv =====
// Package for the complex multi-vector inner product block.
// Holds shared constants, the lane control struct and the active-count helper.
// No dependencies.
package cmip_pkg;

    localparam int PHI_PORTS          = 4;
    localparam int MAX_VECTORS_DEF    = 4;
    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int ACCUM_WIDTH_DEF    = 48;
    localparam int CNT_W              = 3;
    localparam int VIDX_W             = 2;

    localparam logic [CNT_W-1:0] VCOUNT_RESET = CNT_W'(4);

    typedef struct packed {
        logic advance;  // pipeline moves this cycle
        logic step;     // the accumulate-stage item updates this lane
        logic clear;    // the accumulate-stage item ends the run
    } t_lane_ctrl;

    // A count of zero acts as one; counts above the lane count saturate.
    function automatic logic [CNT_W-1:0] active_count(
        input logic [CNT_W-1:0] cnt,
        input logic [CNT_W-1:0] lim
    );
        logic [CNT_W-1:0] n;
        n = (cnt == '0) ? CNT_W'(1) : cnt;
        if (n > lim) begin
            n = lim;
        end
        return n;
    endfunction

endpackage

// ===== hw/rtl/complex_multi_inner_product.sv =====
// Top level of the complex multi-vector conjugate inner product block.
// Depends on cmip_pkg and cmip_lane.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+----------------------------------------
//   input    | i_in_valid / o_in_ready    | psi, phi0..phi3 (real, imag), last flag
//   output   | o_out_valid / i_out_ready  | vector index, sums, overflow, last flag
//   config   | i_cfg_we                   | i_cfg_data = vector count
//
// One element request is taken per cycle while the input is not stalled. Each request
// passes an input register, a product register and the accumulators; the results of
// a last request are loaded into the result buffer as it leaves the accumulators, and
// leave one per cycle while i_out_ready is high.
// Input stalls only when a last request reaches the accumulators while the previous
// run's results are still draining. Synchronous reset clears all valids, the
// accumulators and flags, and sets the vector count to four.
module complex_multi_inner_product #(
    parameter int MAX_VECTORS  = cmip_pkg::MAX_VECTORS_DEF,
    parameter int SAMPLE_WIDTH = cmip_pkg::SAMPLE_WIDTH_DEF,
    parameter int ACCUM_WIDTH  = cmip_pkg::ACCUM_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cmip_pkg::CNT_W-1:0]      i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_psi_real,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_psi_imag,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_phi0_real,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_phi0_imag,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_phi1_real,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_phi1_imag,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_phi2_real,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_phi2_imag,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_phi3_real,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_phi3_imag,
    input  logic                            i_last_element,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [cmip_pkg::VIDX_W-1:0]     o_vector_index,
    output logic signed [ACCUM_WIDTH-1:0]   o_sum_real,
    output logic signed [ACCUM_WIDTH-1:0]   o_sum_imag,
    output logic                            o_overflowed,
    output logic                            o_last_result
);
    import cmip_pkg::*;

    localparam int LANES = (MAX_VECTORS < PHI_PORTS) ? MAX_VECTORS : PHI_PORTS;
    localparam int K_W   = (LANES > 1) ? $clog2(LANES) : 1;

    logic [CNT_W-1:0]               r_vector_count;

    logic                           r_a_valid, r_a_last;
    logic [CNT_W-1:0]               r_a_n;
    logic signed [SAMPLE_WIDTH-1:0] r_a_psi_real, r_a_psi_imag;
    logic signed [SAMPLE_WIDTH-1:0] r_a_phi_real [LANES];
    logic signed [SAMPLE_WIDTH-1:0] r_a_phi_imag [LANES];

    logic                           r_p_valid, r_p_last;
    logic [CNT_W-1:0]               r_p_n;

    logic                           r_ob_valid;
    logic [VIDX_W-1:0]              r_ob_k, r_ob_last;
    logic signed [ACCUM_WIDTH-1:0]  r_ob_real [LANES];
    logic signed [ACCUM_WIDTH-1:0]  r_ob_imag [LANES];
    logic                           r_ob_ovf  [LANES];

    logic signed [SAMPLE_WIDTH-1:0] phi_real_in [PHI_PORTS];
    logic signed [SAMPLE_WIDTH-1:0] phi_imag_in [PHI_PORTS];
    logic signed [ACCUM_WIDTH-1:0]  lane_real   [LANES];
    logic signed [ACCUM_WIDTH-1:0]  lane_imag   [LANES];
    logic                           lane_ovf    [LANES];
    t_lane_ctrl                     lane_ctrl   [LANES];

    logic              in_accept, out_accept, ob_at_last, stall, advance, load;
    logic [CNT_W-1:0]  p_last_idx;

    assign phi_real_in = '{i_phi0_real, i_phi1_real, i_phi2_real, i_phi3_real};
    assign phi_imag_in = '{i_phi0_imag, i_phi1_imag, i_phi2_imag, i_phi3_imag};

    assign ob_at_last = (r_ob_k == r_ob_last);
    assign out_accept = r_ob_valid & i_out_ready;
    // A finished run can enter the buffer only once the previous one has left it.
    assign stall      = r_p_valid & r_p_last & r_ob_valid & !(i_out_ready & ob_at_last);
    assign advance    = !stall;
    assign o_in_ready = advance;
    assign in_accept  = i_in_valid & o_in_ready;
    assign load       = advance & r_p_valid & r_p_last;
    assign p_last_idx = r_p_n - CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vector_count <= VCOUNT_RESET;
        end else if (i_cfg_we) begin
            r_vector_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_p_valid <= 1'b0;
        end else if (advance) begin
            r_a_valid <= in_accept;
            r_p_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_a_last     <= i_last_element;
            r_a_n        <= active_count(r_vector_count, CNT_W'(LANES));
            r_a_psi_real <= i_psi_real;
            r_a_psi_imag <= i_psi_imag;
            for (int k = 0; k < LANES; k++) begin
                r_a_phi_real[k] <= phi_real_in[k];
                r_a_phi_imag[k] <= phi_imag_in[k];
            end
        end
        if (advance) begin
            r_p_last <= r_a_last;
            r_p_n    <= r_a_n;
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        assign lane_ctrl[g].advance = advance;
        assign lane_ctrl[g].step    = advance & r_p_valid & (CNT_W'(g) < r_p_n);
        assign lane_ctrl[g].clear   = load;

        cmip_lane #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .ACCUM_WIDTH  (ACCUM_WIDTH)
        ) u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (lane_ctrl[g]),
            .i_psi_real   (r_a_psi_real),
            .i_psi_imag   (r_a_psi_imag),
            .i_phi_real   (r_a_phi_real[g]),
            .i_phi_imag   (r_a_phi_imag[g]),
            .o_sum_real   (lane_real[g]),
            .o_sum_imag   (lane_imag[g]),
            .o_overflowed (lane_ovf[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_valid <= 1'b0;
            r_ob_k     <= '0;
            r_ob_last  <= '0;
        end else if (load) begin
            r_ob_valid <= 1'b1;
            r_ob_k     <= '0;
            r_ob_last  <= p_last_idx[VIDX_W-1:0];
        end else if (out_accept) begin
            if (ob_at_last) begin
                r_ob_valid <= 1'b0;
            end else begin
                r_ob_k <= r_ob_k + VIDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int k = 0; k < LANES; k++) begin
                r_ob_real[k] <= lane_real[k];
                r_ob_imag[k] <= lane_imag[k];
                r_ob_ovf[k]  <= lane_ovf[k];
            end
        end
    end

    assign o_out_valid    = r_ob_valid;
    assign o_vector_index = r_ob_k;
    assign o_sum_real     = r_ob_real[r_ob_k[K_W-1:0]];
    assign o_sum_imag     = r_ob_imag[r_ob_k[K_W-1:0]];
    assign o_overflowed   = r_ob_ovf[r_ob_k[K_W-1:0]];
    assign o_last_result  = ob_at_last;

endmodule

// ===== hw/rtl/cmip_lane.sv =====
// One lane: conj(phi) * psi products, then saturating real/imag accumulators.
// Depends on cmip_pkg.
module cmip_lane #(
    parameter int SAMPLE_WIDTH = cmip_pkg::SAMPLE_WIDTH_DEF,
    parameter int ACCUM_WIDTH  = cmip_pkg::ACCUM_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  cmip_pkg::t_lane_ctrl           i_ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] i_psi_real,
    input  logic signed [SAMPLE_WIDTH-1:0] i_psi_imag,
    input  logic signed [SAMPLE_WIDTH-1:0] i_phi_real,
    input  logic signed [SAMPLE_WIDTH-1:0] i_phi_imag,
    output logic signed [ACCUM_WIDTH-1:0]  o_sum_real,
    output logic signed [ACCUM_WIDTH-1:0]  o_sum_imag,
    output logic                           o_overflowed
);
    import cmip_pkg::*;

    localparam int PROD_W = 2 * SAMPLE_WIDTH;
    localparam int PAIR_W = PROD_W + 1;
    localparam int SUM_W  = ((ACCUM_WIDTH > PAIR_W) ? ACCUM_WIDTH : PAIR_W) + 1;

    logic signed [PROD_W-1:0]      r_rr, r_ii, r_ri, r_ir;
    logic signed [ACCUM_WIDTH-1:0] r_acc_real, r_acc_imag;
    logic                          r_ovf;

    logic signed [ACCUM_WIDTH-1:0] n_acc_real, n_acc_imag;
    logic                          n_ovf;
    logic [PAIR_W-1:0]             pair_real, pair_imag;
    logic [ACCUM_WIDTH:0]          sat_real, sat_imag;

    // Exact acc + pair, clamped to the accumulator range; top bit flags a clamp.
    function automatic logic [ACCUM_WIDTH:0] sat_add(
        input logic [ACCUM_WIDTH-1:0] acc,
        input logic [PAIR_W-1:0]      pair
    );
        logic [SUM_W-1:0]             sum;
        logic [SUM_W-ACCUM_WIDTH:0]   upper;
        logic [ACCUM_WIDTH-1:0]       lim;
        sum   = {{(SUM_W-ACCUM_WIDTH){acc[ACCUM_WIDTH-1]}}, acc}
              + {{(SUM_W-PAIR_W){pair[PAIR_W-1]}}, pair};
        upper = sum[SUM_W-1:ACCUM_WIDTH-1];
        lim   = sum[SUM_W-1] ? {1'b1, {(ACCUM_WIDTH-1){1'b0}}}
                             : {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
        if ((&upper) || !(|upper)) begin
            return {1'b0, sum[ACCUM_WIDTH-1:0]};
        end
        return {1'b1, lim};
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_ctrl.advance) begin
            r_rr <= i_phi_real * i_psi_real;
            r_ii <= i_phi_imag * i_psi_imag;
            r_ri <= i_phi_real * i_psi_imag;
            r_ir <= i_phi_imag * i_psi_real;
        end
    end

    always_comb begin
        pair_real = {r_rr[PROD_W-1], r_rr} + {r_ii[PROD_W-1], r_ii};
        pair_imag = {r_ri[PROD_W-1], r_ri} - {r_ir[PROD_W-1], r_ir};
        sat_real  = sat_add(r_acc_real, pair_real);
        sat_imag  = sat_add(r_acc_imag, pair_imag);
        if (i_ctrl.step) begin
            n_acc_real = sat_real[ACCUM_WIDTH-1:0];
            n_acc_imag = sat_imag[ACCUM_WIDTH-1:0];
            n_ovf      = r_ovf | sat_real[ACCUM_WIDTH] | sat_imag[ACCUM_WIDTH];
        end else begin
            n_acc_real = r_acc_real;
            n_acc_imag = r_acc_imag;
            n_ovf      = r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_real <= '0;
            r_acc_imag <= '0;
            r_ovf      <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_acc_real <= '0;
            r_acc_imag <= '0;
            r_ovf      <= 1'b0;
        end else begin
            r_acc_real <= n_acc_real;
            r_acc_imag <= n_acc_imag;
            r_ovf      <= n_ovf;
        end
    end

    assign o_sum_real   = n_acc_real;
    assign o_sum_imag   = n_acc_imag;
    assign o_overflowed = n_ovf;

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the complex multi-vector conjugate inner product block.
// Predicts each lane sum in a small tracker class and checks every result request.
// Depends on cmip_pkg and complex_multi_inner_product.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cmip_pkg::*;

    localparam int LANES = 4;
    localparam int SW = 16;
    localparam int AW = 48;
    localparam longint ACC_MAX = (longint'(1) <<< (AW - 1)) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    localparam logic [SW-1:0] MAX_POS = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] MAX_NEG = {1'b1, {(SW-1){1'b0}}};
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES = 120;
    localparam int RANDOM_ITEMS = 420;
    localparam int SAT_ITEMS = 20;
    localparam int CYCLE_LIMIT = 100000;

    typedef struct packed {
        logic signed [SW-1:0] psi_re;
        logic signed [SW-1:0] psi_im;
        logic [LANES-1:0][SW-1:0] phi_re;
        logic [LANES-1:0][SW-1:0] phi_im;
        logic last;
    } t_element;

    typedef struct packed {
        logic [VIDX_W-1:0] vector_index;
        logic signed [AW-1:0] sum_real;
        logic signed [AW-1:0] sum_imag;
        logic overflowed;
        logic last_result;
    } t_sum_result;

    class inner_product_tracker;
        logic [CNT_W-1:0] vcount;
        longint sum_re [LANES];
        longint sum_im [LANES];
        bit sat_flag [LANES];
        t_sum_result pending_sums [$];
        int errors;

        function new();
            errors = 0;
            vcount = VCOUNT_RESET;
            clear_sums();
        endfunction

        function void clear_sums();
            for (int k = 0; k < LANES; k++) begin
                sum_re[k] = 0;
                sum_im[k] = 0;
                sat_flag[k] = 1'b0;
            end
        endfunction

        function longint saturate(longint v, inout bit flag);
            if (v > ACC_MAX) begin
                flag = 1'b1;
                return ACC_MAX;
            end
            if (v < ACC_MIN) begin
                flag = 1'b1;
                return ACC_MIN;
            end
            return v;
        endfunction

        function string describe(t_sum_result r);
            return $sformatf("idx %0d re %0d im %0d ovf %0b last %0b",
                             r.vector_index, r.sum_real, r.sum_imag,
                             r.overflowed, r.last_result);
        endfunction

        // Adds conj(phi) * psi to every active lane; a last request closes the run.
        function void take_element(t_element e);
            int n;
            longint s_re, s_im, p_re, p_im;
            n = (vcount == '0) ? 1 : int'(vcount);
            if (n > LANES) n = LANES;
            s_re = longint'(e.psi_re);
            s_im = longint'(e.psi_im);
            for (int k = 0; k < n; k++) begin
                p_re = longint'($signed(e.phi_re[k]));
                p_im = longint'($signed(e.phi_im[k]));
                sum_re[k] = saturate(sum_re[k] + p_re * s_re + p_im * s_im, sat_flag[k]);
                sum_im[k] = saturate(sum_im[k] + p_re * s_im - p_im * s_re, sat_flag[k]);
            end
            if (e.last) begin
                for (int k = 0; k < n; k++) begin
                    pending_sums.push_back(t_sum_result'{vector_index: VIDX_W'(k),
                                                         sum_real: sum_re[k][AW-1:0],
                                                         sum_imag: sum_im[k][AW-1:0],
                                                         overflowed: sat_flag[k],
                                                         last_result: (k == n - 1)});
                end
                clear_sums();
            end
        endfunction

        function void check_lane_sum(t_sum_result got);
            t_sum_result want;
            if (pending_sums.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: %s", $time, describe(got));
                return;
            end
            want = pending_sums.pop_front();
            if (got !== want) begin
                errors++;
                $display("%0t: mismatch: expected %s, actual %s",
                         $time, describe(want), describe(got));
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CNT_W-1:0] i_cfg_data;
    logic i_in_valid;
    logic o_in_ready;
    logic signed [SW-1:0] i_psi_real, i_psi_imag;
    logic signed [SW-1:0] i_phi0_real, i_phi0_imag, i_phi1_real, i_phi1_imag;
    logic signed [SW-1:0] i_phi2_real, i_phi2_imag, i_phi3_real, i_phi3_imag;
    logic i_last_element;
    logic o_out_valid;
    logic i_out_ready;
    logic [VIDX_W-1:0] o_vector_index;
    logic signed [AW-1:0] o_sum_real, o_sum_imag;
    logic o_overflowed, o_last_result;

    inner_product_tracker tracker;
    bit hold_request;
    int burst_left;
    int gap_max;

    complex_multi_inner_product uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_psi_real(i_psi_real), .i_psi_imag(i_psi_imag),
        .i_phi0_real(i_phi0_real), .i_phi0_imag(i_phi0_imag),
        .i_phi1_real(i_phi1_real), .i_phi1_imag(i_phi1_imag),
        .i_phi2_real(i_phi2_real), .i_phi2_imag(i_phi2_imag),
        .i_phi3_real(i_phi3_real), .i_phi3_imag(i_phi3_imag),
        .i_last_element(i_last_element),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_vector_index(o_vector_index), .o_sum_real(o_sum_real), .o_sum_imag(o_sum_imag),
        .o_overflowed(o_overflowed), .o_last_result(o_last_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [SW-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return MAX_NEG;
            1: return MAX_POS;
            2: return '0;
            3: return '1;
            default: return SW'($urandom);
        endcase
    endfunction

    function automatic t_element random_element(bit last);
        t_element e;
        e.psi_re = rand_sample();
        e.psi_im = rand_sample();
        for (int k = 0; k < LANES; k++) begin
            e.phi_re[k] = rand_sample();
            e.phi_im[k] = rand_sample();
        end
        e.last = last;
        return e;
    endfunction

    function automatic t_element uniform_element(logic [SW-1:0] s_re, logic [SW-1:0] s_im,
                                                 logic [SW-1:0] p_re, logic [SW-1:0] p_im,
                                                 bit last);
        t_element e;
        e.psi_re = s_re;
        e.psi_im = s_im;
        for (int k = 0; k < LANES; k++) begin
            e.phi_re[k] = p_re;
            e.phi_im[k] = p_im;
        end
        e.last = last;
        return e;
    endfunction

    task automatic drive_payload(t_element e);
        i_psi_real <= e.psi_re;
        i_psi_imag <= e.psi_im;
        i_phi0_real <= e.phi_re[0];
        i_phi0_imag <= e.phi_im[0];
        i_phi1_real <= e.phi_re[1];
        i_phi1_imag <= e.phi_im[1];
        i_phi2_real <= e.phi_re[2];
        i_phi2_imag <= e.phi_im[2];
        i_phi3_real <= e.phi_re[3];
        i_phi3_imag <= e.phi_im[3];
        i_last_element <= e.last;
    endtask

    // Valid stays high on return, so a following request goes out back to back.
    task automatic send_element(t_element e);
        drive_payload(e);
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.take_element(e);
    endtask

    task automatic pause(int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic pace();
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            pause($urandom_range(0, gap_max));
        end
    endtask

    // Requests that end no run produce nothing, so settle goes on waiting after the
    // last result to let them clear the pipeline before anything changes.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending_sums.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(logic [CNT_W-1:0] v);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.vcount = v;
    endtask

    initial begin : stimulus
        t_element e;
        int phase_len;
        int random_sent;
        bit hold_done;
        tracker = new();
        hold_request = 1'b0;
        burst_left = 1;
        gap_max = 3;
        e = '0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        drive_payload(e);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The count is still at its reset value of four here.
        send_element(uniform_element('0, '0, '0, '0, 1'b1));
        send_element(uniform_element(MAX_POS, MAX_POS, MAX_POS, MAX_POS, 1'b0));
        send_element(uniform_element(MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG, 1'b0));
        send_element(uniform_element(MAX_POS, MAX_NEG, MAX_NEG, MAX_POS, 1'b0));
        send_element(random_element(1'b1));

        // A count of zero acts as one, and counts above four act as four.
        write_count(CNT_W'(0));
        send_element(random_element(1'b0));
        send_element(random_element(1'b1));
        write_count(CNT_W'(7));
        send_element(random_element(1'b1));
        write_count(CNT_W'(1));
        send_element(random_element(1'b1));
        write_count(CNT_W'(5));
        send_element(random_element(1'b1));

        // Count shrinks, then grows, in the middle of a run.
        write_count(CNT_W'(4));
        send_element(random_element(1'b0));
        send_element(random_element(1'b0));
        write_count(CNT_W'(2));
        send_element(random_element(1'b1));
        write_count(CNT_W'(1));
        send_element(random_element(1'b0));
        send_element(random_element(1'b0));
        write_count(CNT_W'(3));
        send_element(random_element(1'b1));

        // One run of extreme samples pushes each lane hard in a different
        // direction; the closing requests flip psi so every sum turns back.
        write_count(CNT_W'(4));
        for (int i = 0; i < SAT_ITEMS + 3; i++) begin
            e.psi_re = (i < SAT_ITEMS) ? MAX_NEG : MAX_POS;
            e.psi_im = (i < SAT_ITEMS) ? MAX_NEG : MAX_POS;
            e.phi_re[0] = MAX_NEG;
            e.phi_im[0] = MAX_NEG;
            e.phi_re[1] = MAX_POS;
            e.phi_im[1] = MAX_POS;
            e.phi_re[2] = MAX_NEG;
            e.phi_im[2] = MAX_POS;
            e.phi_re[3] = MAX_POS;
            e.phi_im[3] = MAX_NEG;
            e.last = (i == SAT_ITEMS + 2);
            send_element(e);
        end

        random_sent = 0;
        hold_done = 1'b0;
        while (random_sent < RANDOM_ITEMS) begin
            write_count(CNT_W'($urandom_range(0, 7)));
            case ($urandom_range(0, 2))
                0: gap_max = 0;
                1: gap_max = 3;
                default: gap_max = 12;
            endcase
            phase_len = $urandom_range(20, 60);
            repeat (phase_len) begin
                send_element(random_element($urandom_range(0, 3) == 0));
                pace();
            end
            random_sent += phase_len;
            if (!hold_done && random_sent >= RANDOM_ITEMS / 3) begin
                // The result side holds off while requests keep coming, so the
                // result buffer fills up and the input has to stall.
                write_count(CNT_W'(4));
                hold_request = 1'b1;
                for (int i = 0; i < 40; i++) begin
                    send_element(random_element(i % 2 == 1));
                end
                random_sent += 40;
                hold_done = 1'b1;
            end
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending_sums.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin : result_sink
        t_sum_result got;
        int hold_left;
        int rx_cycle;
        bit hold_seen;
        i_out_ready <= 1'b0;
        hold_left = 0;
        rx_cycle = 0;
        hold_seen = 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (o_out_valid && i_out_ready) begin
                got = '{vector_index: o_vector_index, sum_real: o_sum_real,
                        sum_imag: o_sum_imag, overflowed: o_overflowed,
                        last_result: o_last_result};
                tracker.check_lane_sum(got);
            end
            if (hold_request && !hold_seen) begin
                hold_left = HOLD_CYCLES;
                hold_seen = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                case ((rx_cycle / 300) % 4)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 1) == 1);
                    2: i_out_ready <= (rx_cycle % 5 >= 2);
                    default: i_out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
            rx_cycle++;
            @(posedge i_clk);
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/cmip_pkg.sv
hw/rtl/cmip_lane.sv
hw/rtl/complex_multi_inner_product.sv
bench/tb.sv
